### hdl/mmpl_pkg.sv
// Shared action codes and bit constants for the MCU mailbox and port latch.
package mmpl_pkg;

  // Widths of the bus access fields
  localparam int unsigned ActionW = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PlayerW = 6;

  typedef logic [ActionW-1:0] action_t;
  typedef logic [ByteW-1:0]   byte_t;

  // Bus access codes
  localparam action_t ACT_HOST_RD = 4'd0;
  localparam action_t ACT_HOST_WR = 4'd1;
  localparam action_t ACT_A_RD    = 4'd2;
  localparam action_t ACT_A_WR    = 4'd3;
  localparam action_t ACT_DIRA_WR = 4'd4;
  localparam action_t ACT_C_RD    = 4'd5;
  localparam action_t ACT_C_WR    = 4'd6;
  localparam action_t ACT_DIRC_WR = 4'd7;
  localparam action_t ACT_IN_RD   = 4'd8;

  // Port C strobe bit positions
  localparam int unsigned STROBE_IN_BIT  = 2;
  localparam int unsigned STROBE_OUT_BIT = 3;

  // Input read flag positions (active low flags)
  localparam int unsigned FLAG_HOST_BIT = 6;
  localparam int unsigned FLAG_MCU_BIT  = 7;

  // Port C status bit positions
  localparam int unsigned STAT_HOST_BIT = 0;
  localparam int unsigned STAT_MCU_BIT  = 1;

endpackage

### hdl/mcu_mailbox_port_latch_top.sv
// Top level of the host/MCU byte mailbox with GPIO ports A and C.
//
// Usage:
//   Each input word is one bus access: in_action picks host mailbox read or
//   write, port A or C read or write, a direction register write or the
//   player input read. in_data carries the byte for writes, in_player_bits
//   the six external lines for the input read.
//   Every access yields exactly one output word on out_read_data: the byte
//   read, or zero for writes and unused codes.
// Pipeline and throughput:
//   out_valid rises in the cycle after acceptance. A new access is taken
//   every cycle unless the output stalls; the state update and read mux form
//   one combinational pass ahead of the single output register.
// Reset:
//   rst_n low clears all port, direction and mailbox registers and both
//   flags, and empties the output register.
// Stalls:
//   While out_ready is low and a word waits, in_ready drops; the waiting
//   word holds. When out_ready is high the output register is refilled in
//   the same cycle it drains, so there are no bubbles.
module mcu_mailbox_port_latch_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mmpl_pkg::ActionW-1:0]        in_action,
  input  logic [mmpl_pkg::ByteW-1:0]          in_data,
  input  logic [mmpl_pkg::PlayerW-1:0]        in_player_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mmpl_pkg::ByteW-1:0]          out_read_data
);
  import mmpl_pkg::*;

  // Architectural state
  byte_t a_out_r, a_in_r, dir_a_r, c_out_r, dir_c_r, host_byte_r, mcu_byte_r;
  logic  host_wrote_r, mcu_wrote_r;
  byte_t a_out_nxt, a_in_nxt, dir_a_nxt, c_out_nxt, dir_c_nxt;
  byte_t host_byte_nxt, mcu_byte_nxt;
  logic  host_wrote_nxt, mcu_wrote_nxt;

  // Output register
  logic  out_valid_r;
  byte_t out_data_r;
  byte_t rd_nxt;

  logic  acc;
  logic  strobe_in_fall, strobe_out_fall;
  byte_t c_stat;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  // Falling edges on the port C strobes, judged against the old latch
  assign strobe_in_fall  = dir_c_r[STROBE_IN_BIT] && c_out_r[STROBE_IN_BIT]
                           && !in_data[STROBE_IN_BIT];
  assign strobe_out_fall = dir_c_r[STROBE_OUT_BIT] && c_out_r[STROBE_OUT_BIT]
                           && !in_data[STROBE_OUT_BIT];

  // Port C status byte
  always_comb begin
    c_stat                = '0;
    c_stat[STAT_HOST_BIT] = host_wrote_r;
    c_stat[STAT_MCU_BIT]  = !mcu_wrote_r;
  end

  // Access decode: next state and read word
  always_comb begin
    a_out_nxt      = a_out_r;
    a_in_nxt       = a_in_r;
    dir_a_nxt      = dir_a_r;
    c_out_nxt      = c_out_r;
    dir_c_nxt      = dir_c_r;
    host_byte_nxt  = host_byte_r;
    mcu_byte_nxt   = mcu_byte_r;
    host_wrote_nxt = host_wrote_r;
    mcu_wrote_nxt  = mcu_wrote_r;
    rd_nxt         = '0;
    case (in_action)
      ACT_HOST_RD: begin
        mcu_wrote_nxt = 1'b0;
        rd_nxt        = mcu_byte_r;
      end
      ACT_HOST_WR: begin
        host_byte_nxt  = in_data;
        host_wrote_nxt = 1'b1;
      end
      ACT_A_RD: begin
        rd_nxt = (a_out_r & dir_a_r) | (a_in_r & ~dir_a_r);
      end
      ACT_A_WR: begin
        a_out_nxt = in_data;
      end
      ACT_DIRA_WR: begin
        dir_a_nxt = in_data;
      end
      ACT_C_RD: begin
        rd_nxt = (c_out_r & dir_c_r) | (c_stat & ~dir_c_r);
      end
      ACT_C_WR: begin
        if (strobe_in_fall) begin
          a_in_nxt       = host_byte_r;
          host_wrote_nxt = 1'b0;
        end
        if (strobe_out_fall) begin
          mcu_byte_nxt  = a_out_r;
          mcu_wrote_nxt = 1'b1;
        end
        c_out_nxt = in_data;
      end
      ACT_DIRC_WR: begin
        dir_c_nxt = in_data;
      end
      ACT_IN_RD: begin
        rd_nxt[PlayerW-1:0]  = in_player_bits;
        rd_nxt[FLAG_HOST_BIT] = !host_wrote_r;
        rd_nxt[FLAG_MCU_BIT]  = !mcu_wrote_r;
      end
      default: begin
        rd_nxt = '0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_out_r      <= '0;
      a_in_r       <= '0;
      dir_a_r      <= '0;
      c_out_r      <= '0;
      dir_c_r      <= '0;
      host_byte_r  <= '0;
      mcu_byte_r   <= '0;
      host_wrote_r <= 1'b0;
      mcu_wrote_r  <= 1'b0;
    end else if (acc) begin
      a_out_r      <= a_out_nxt;
      a_in_r       <= a_in_nxt;
      dir_a_r      <= dir_a_nxt;
      c_out_r      <= c_out_nxt;
      dir_c_r      <= dir_c_nxt;
      host_byte_r  <= host_byte_nxt;
      mcu_byte_r   <= mcu_byte_nxt;
      host_wrote_r <= host_wrote_nxt;
      mcu_wrote_r  <= mcu_wrote_nxt;
    end
  end

  // Output register: refilled whenever an access is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= rd_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Checks
  a_host_wr_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_action == ACT_HOST_WR |=> host_wrote_r && host_byte_r == $past(in_data))
    else $error("host write did not latch byte and flag");

  a_host_rd_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_action == ACT_HOST_RD |=> !mcu_wrote_r && out_read_data == mcu_byte_r)
    else $error("host read did not clear MCU flag or return MCU byte");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_action == ACT_HOST_WR || in_action == ACT_A_WR ||
            in_action == ACT_DIRA_WR || in_action == ACT_C_WR ||
            in_action == ACT_DIRC_WR) |=> out_valid && out_read_data == '0)
    else $error("write access returned non-zero word");

  a_c_wr_updates_latch: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_action == ACT_C_WR |=> c_out_r == $past(in_data))
    else $error("port C write did not update the output latch");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without a blocked output word");

endmodule

### test/tb_top.sv
// Self-checking testbench for the host/MCU byte mailbox with ports A and C.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmpl_pkg::*;

  typedef logic [PlayerW-1:0] player_t;

  // Action codes the block decodes as no-ops
  localparam action_t ACT_SPARE_FIRST = 4'd9;
  localparam action_t ACT_SPARE_LAST  = 4'd15;

  localparam byte_t StrobeInMask  = byte_t'(1 << STROBE_IN_BIT);
  localparam byte_t StrobeOutMask = byte_t'(1 << STROBE_OUT_BIT);
  localparam byte_t StrobeMask    = StrobeInMask | StrobeOutMask;

  localparam int RandomWords  = 1050;
  localparam int IdleLimit    = 2000;
  localparam int ReportLimit  = 20;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  action_t in_action;
  byte_t   in_data;
  player_t in_player_bits;
  logic    out_valid;
  logic    out_ready;
  byte_t   out_read_data;

  mcu_mailbox_port_latch_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_data        (in_data),
    .in_player_bits (in_player_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the port and mailbox registers
  byte_t port_a_out, port_a_in, port_a_dir;
  byte_t port_c_out, port_c_dir;
  byte_t host_latch, mcu_latch;
  logic  host_pending, mcu_pending;

  byte_t expected_bytes[$];
  int    mismatch_count = 0;
  int    sent_words = 0;
  int    burst_left = 0;

  task automatic clear_mirror();
    port_a_out = '0; port_a_in = '0; port_a_dir = '0;
    port_c_out = '0; port_c_dir = '0;
    host_latch = '0; mcu_latch = '0;
    host_pending = 1'b0; mcu_pending = 1'b0;
  endtask

  // Applies one bus access to the mirror and returns the byte it reads back
  function automatic byte_t access_result(action_t act, byte_t d, player_t pl);
    byte_t r;
    byte_t stat;
    r = '0;
    case (act)
      ACT_HOST_RD: begin
        mcu_pending = 1'b0;
        r = mcu_latch;
      end
      ACT_HOST_WR: begin
        host_latch = d;
        host_pending = 1'b1;
      end
      ACT_A_RD:    r = (port_a_out & port_a_dir) | (port_a_in & ~port_a_dir);
      ACT_A_WR:    port_a_out = d;
      ACT_DIRA_WR: port_a_dir = d;
      ACT_C_RD: begin
        stat = '0;
        stat[STAT_HOST_BIT] = host_pending;
        stat[STAT_MCU_BIT]  = !mcu_pending;
        r = (port_c_out & port_c_dir) | (stat & ~port_c_dir);
      end
      ACT_C_WR: begin
        // strobes act on a driven 1 -> 0 transition, tested against the old latch
        if (port_c_dir[STROBE_IN_BIT] && port_c_out[STROBE_IN_BIT] && !d[STROBE_IN_BIT]) begin
          host_pending = 1'b0;
          port_a_in = host_latch;
        end
        if (port_c_dir[STROBE_OUT_BIT] && port_c_out[STROBE_OUT_BIT] &&
            !d[STROBE_OUT_BIT]) begin
          mcu_pending = 1'b1;
          mcu_latch = port_a_out;
        end
        port_c_out = d;
      end
      ACT_DIRC_WR: port_c_dir = d;
      ACT_IN_RD: begin
        r = byte_t'(pl);
        r[FLAG_HOST_BIT] = !host_pending;
        r[FLAG_MCU_BIT]  = !mcu_pending;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, byte_t got, byte_t want);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("[%0t] %s: got %02h want %02h", $realtime, what, got, want);
  endtask

  // Receiver: ready pattern in one of four randomly chosen modes
  int unsigned ready_mode = 0;
  int unsigned ready_tick = 0;
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 50 == 0)
      ready_mode <= $urandom_range(0, 3);
    if (!rst_n)
      out_ready <= 1'b0;
    else begin
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= (ready_tick % 7 == 0);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0)
        report_mismatch("unexpected word", out_read_data, 8'h00);
      else if (out_read_data !== expected_bytes[0])
        report_mismatch("read_data", out_read_data, expected_bytes.pop_front());
      else
        void'(expected_bytes.pop_front());
    end
  end

  // Watchdog on cycles with no handshake on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Sender pacing: bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0)
      burst_left--;
    else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 15);
    end
  endtask

  // Drives one word, waits for it to be taken and records what it should read
  task automatic send_access(action_t act, byte_t d, player_t pl,
                             bit fixed = 1'b0, byte_t fixed_val = '0);
    byte_t want;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_data        <= d;
    in_player_bits <= pl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = access_result(act, d, pl);
    expected_bytes.push_back(fixed ? fixed_val : want);
    sent_words++;
    pace_sender();
  endtask

  // Hold off until every outstanding word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic player_t rand_players();
    return player_t'($urandom_range(0, 63));
  endfunction

  // One host-to-MCU and MCU-to-host exchange with random contents;
  // a share of them is deliberately mangled (strobes undriven or not raised)
  task automatic exchange_sequence();
    bit    mangle;
    byte_t c_val;
    mangle = ($urandom_range(0, 4) == 0);
    send_access(ACT_HOST_WR, rand_byte(), rand_players());
    send_access(ACT_DIRC_WR, mangle ? rand_byte() : (rand_byte() | StrobeMask),
                rand_players());
    c_val = rand_byte();
    send_access(ACT_C_WR, mangle ? c_val : (c_val | StrobeMask), rand_players());
    send_access(ACT_C_RD, rand_byte(), rand_players());
    c_val = rand_byte();
    send_access(ACT_C_WR, mangle ? c_val : ((c_val & ~StrobeInMask) | StrobeOutMask),
                rand_players());
    if ($urandom_range(0, 1) == 1)
      send_access(ACT_DIRA_WR, rand_byte(), rand_players());
    send_access(ACT_A_RD, rand_byte(), rand_players());
    send_access(ACT_A_WR, rand_byte(), rand_players());
    send_access(ACT_IN_RD, rand_byte(), rand_players());
    c_val = rand_byte();
    send_access(ACT_C_WR, mangle ? c_val : (c_val & ~StrobeOutMask), rand_players());
    send_access(ACT_C_RD, rand_byte(), rand_players());
    send_access(ACT_HOST_RD, rand_byte(), rand_players());
  endtask

  // Single access of any code, spare codes included
  task automatic noise_access();
    action_t act;
    byte_t   d;
    int      pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      act = action_t'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    else
      act = action_t'($urandom_range(ACT_HOST_RD, ACT_IN_RD));
    d = rand_byte();
    // keep the strobes driven most of the time so C writes can fire them
    if (act == ACT_DIRC_WR && $urandom_range(0, 3) != 0)
      d = d | StrobeMask;
    send_access(act, d, rand_players());
  endtask

  // Directed stimulus; 'fixed' rows carry their expected read-back byte
  typedef struct packed {
    action_t act;
    byte_t   data;
    player_t players;
    logic    fixed;
    byte_t   fixed_val;
  } access_row_t;

  localparam int DirectedRows = 26;
  access_row_t directed_rows [DirectedRows] = '{
    '{ACT_HOST_RD,    8'h00, 6'h00, 1'b1, 8'h00},  // mailbox empty after reset
    '{ACT_A_RD,       8'h00, 6'h00, 1'b1, 8'h00},
    '{ACT_C_RD,       8'h00, 6'h00, 1'b1, 8'h02},  // only "host has read" set
    '{ACT_IN_RD,      8'h00, 6'h3f, 1'b1, 8'hff},
    '{ACT_IN_RD,      8'hff, 6'h00, 1'b1, 8'hc0},
    '{ACT_SPARE_LAST, 8'hff, 6'h3f, 1'b1, 8'h00},
    '{ACT_HOST_WR,    8'ha5, 6'h00, 1'b1, 8'h00},
    '{ACT_IN_RD,      8'h00, 6'h2a, 1'b0, 8'h00},
    '{ACT_DIRC_WR,    8'h0c, 6'h00, 1'b1, 8'h00},
    '{ACT_C_WR,       8'h0c, 6'h00, 1'b1, 8'h00},  // raise both strobes
    '{ACT_C_WR,       8'h00, 6'h00, 1'b1, 8'h00},  // both fall together
    '{ACT_A_RD,       8'h00, 6'h00, 1'b0, 8'h00},
    '{ACT_A_WR,       8'h3c, 6'h00, 1'b1, 8'h00},
    '{ACT_DIRA_WR,    8'hff, 6'h00, 1'b1, 8'h00},
    '{ACT_A_RD,       8'h00, 6'h00, 1'b0, 8'h00},
    '{ACT_C_RD,       8'h00, 6'h00, 1'b0, 8'h00},
    '{ACT_HOST_RD,    8'h00, 6'h00, 1'b0, 8'h00},
    '{ACT_C_WR,       8'hff, 6'h00, 1'b1, 8'h00},
    '{ACT_C_WR,       8'hf7, 6'h00, 1'b1, 8'h00},  // outbound strobe alone
    '{ACT_HOST_RD,    8'h00, 6'h00, 1'b0, 8'h00},
    '{ACT_DIRC_WR,    8'hff, 6'h00, 1'b1, 8'h00},
    '{ACT_C_RD,       8'h00, 6'h00, 1'b0, 8'h00},  // fully driven port C
    '{ACT_HOST_WR,    8'hff, 6'h00, 1'b1, 8'h00},
    '{ACT_C_WR,       8'hfb, 6'h00, 1'b1, 8'h00},  // inbound strobe alone
    '{ACT_DIRA_WR,    8'h00, 6'h00, 1'b1, 8'h00},
    '{ACT_A_RD,       8'h00, 6'h00, 1'b0, 8'h00}
  };

  // Main stimulus
  initial begin
    int random_start;
    bit paused;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_HOST_RD;
    in_data        <= '0;
    in_player_bits <= '0;
    clear_mirror();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 12;
    for (int i = 0; i < DirectedRows; i++)
      send_access(directed_rows[i].act, directed_rows[i].data, directed_rows[i].players,
                  directed_rows[i].fixed, directed_rows[i].fixed_val);
    drain_results();

    random_start = sent_words;
    paused = 1'b0;
    while (sent_words - random_start < RandomWords) begin
      if ($urandom_range(0, 1) == 1)
        exchange_sequence();
      else
        noise_access();
      if (!paused && sent_words - random_start >= RandomWords / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch("missing word", 8'h00, expected_bytes[0]);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
